FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the parser RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// same-cycle implication, disabled while reset is held
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, disabled while reset is held
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`else

`define ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: hdl/wavps_pkg.sv
// ----------------------------------------------------------------------------
// wavps_pkg
// Types and constants for the RIFF/WAV PCM16 stream parser.
// ----------------------------------------------------------------------------
package wavps_pkg;

    // chunk tags, little-endian as they assemble in the shift word
    localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
    localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
    localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
    localparam logic [31:0] TAG_DATA = 32'h6174_6164;

    localparam logic [31:0] FMT_BODY_BYTES = 32'd16;
    localparam logic [31:0] RATE_AT_RESET  = 32'd16000;
    localparam logic [15:0] FMT_PCM        = 16'd1;
    localparam logic [15:0] MONO           = 16'd1;
    localparam logic [15:0] PCM_BITS       = 16'd16;

    // status codes
    localparam logic [2:0] ST_OK         = 3'd0;
    localparam logic [2:0] ST_BAD_HEADER = 3'd1;
    localparam logic [2:0] ST_NO_DATA    = 3'd2;
    localparam logic [2:0] ST_BAD_FORMAT = 3'd3;
    localparam logic [2:0] ST_SHORT_DATA = 3'd4;

    // result kinds
    localparam logic RES_SAMPLE = 1'b0;
    localparam logic RES_STATUS = 1'b1;

    typedef enum logic [5:0] {
        PH_HEADER  = 6'b000001,
        PH_CHUNK   = 6'b000010,
        PH_FMT     = 6'b000100,
        PH_SKIP    = 6'b001000,
        PH_SAMPLES = 6'b010000,
        PH_DONE    = 6'b100000
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_marker;
    } t_item;

    typedef struct packed {
        logic signed [15:0] sample_value;
        logic               result_kind;
        logic [2:0]         status_code;
        logic               last_result;
    } t_result;

endpackage

FILE: hdl/wavps_parse.sv
// ----------------------------------------------------------------------------
// wavps_parse
// Per-byte parse state and its next-state logic; builds the result word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wavps_parse import wavps_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_step,
    input  t_item       i_item,
    input  logic [31:0] i_req_rate,
    output logic        o_produce,
    output t_result     o_result
);

    t_phase      r_phase,     n_phase;
    logic [3:0]  r_pos,       n_pos;
    logic [31:0] r_shift,     n_shift;
    logic [31:0] r_tag,       n_tag;
    logic [31:0] r_remaining, n_remaining;
    logic [15:0] r_format,    n_format;
    logic [15:0] r_channels,  n_channels;
    logic [31:0] r_rate,      n_rate;
    logic [15:0] r_bits,      n_bits;
    logic [7:0]  r_low,       n_low;
    logic [2:0]  r_pending,   n_pending;

    logic [31:0] asm_word;
    logic        fmt_ok;
    logic [2:0]  end_status;

    assign asm_word = {i_item.data_byte, r_shift[31:8]};
    assign fmt_ok   = (r_format == FMT_PCM) && (r_channels == MONO) &&
                      (r_rate == i_req_rate) && (r_bits == PCM_BITS);

    assign o_produce = i_item.end_marker || ((r_phase == PH_SAMPLES) && r_pos[0]);

    always_comb begin
        case (r_phase)
            PH_HEADER:  end_status = ST_BAD_HEADER;
            PH_SAMPLES: end_status = ST_SHORT_DATA;
            PH_DONE:    end_status = r_pending;
            default:    end_status = ST_NO_DATA;
        endcase
    end

    always_comb begin
        if (i_item.end_marker) begin
            o_result.sample_value = 16'sd0;
            o_result.result_kind  = RES_STATUS;
            o_result.status_code  = end_status;
            o_result.last_result  = 1'b1;
        end else begin
            o_result.sample_value = $signed({i_item.data_byte, r_low});
            o_result.result_kind  = RES_SAMPLE;
            o_result.status_code  = ST_OK;
            o_result.last_result  = 1'b0;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_pos       = r_pos;
        n_shift     = r_shift;
        n_tag       = r_tag;
        n_remaining = r_remaining;
        n_format    = r_format;
        n_channels  = r_channels;
        n_rate      = r_rate;
        n_bits      = r_bits;
        n_low       = r_low;
        n_pending   = r_pending;

        if (i_item.end_marker) begin
            // file closed: back to the start state for the next file
            n_phase     = PH_HEADER;
            n_pos       = 4'd0;
            n_shift     = 32'd0;
            n_tag       = 32'd0;
            n_remaining = 32'd0;
            n_format    = 16'd0;
            n_channels  = 16'd0;
            n_rate      = 32'd0;
            n_bits      = 16'd0;
            n_low       = 8'd0;
            n_pending   = ST_OK;
        end else begin
            case (r_phase)
                PH_SKIP: begin
                    n_remaining = r_remaining - 32'd1;
                    if (r_remaining == 32'd1) begin
                        n_phase = PH_CHUNK;
                        n_pos   = 4'd0;
                    end
                end
                PH_SAMPLES: begin
                    if (!r_pos[0]) begin
                        n_low = i_item.data_byte;
                        n_pos = 4'd1;
                    end else begin
                        n_pos       = 4'd0;
                        n_remaining = r_remaining - 32'd1;
                        if (r_remaining == 32'd1) begin
                            n_phase   = PH_DONE;
                            n_pending = ST_OK;
                        end
                    end
                end
                PH_HEADER: begin
                    n_shift = asm_word;
                    n_pos   = r_pos + 4'd1;
                    if (r_pos == 4'd3 && asm_word != TAG_RIFF) begin
                        n_phase   = PH_DONE;
                        n_pending = ST_BAD_HEADER;
                    end else if (r_pos == 4'd11) begin
                        if (asm_word != TAG_WAVE) begin
                            n_phase   = PH_DONE;
                            n_pending = ST_BAD_HEADER;
                        end else begin
                            n_phase = PH_CHUNK;
                            n_pos   = 4'd0;
                        end
                    end
                end
                PH_CHUNK: begin
                    n_shift = asm_word;
                    n_pos   = r_pos + 4'd1;
                    if (r_pos == 4'd3) begin
                        n_tag = asm_word;
                    end else if (r_pos == 4'd7) begin
                        // asm_word is the chunk size here
                        if (r_tag == TAG_FMT) begin
                            n_remaining = asm_word;
                            n_phase     = PH_FMT;
                            n_pos       = 4'd0;
                        end else if (r_tag == TAG_DATA) begin
                            if (asm_word == 32'd0) begin
                                n_phase   = PH_DONE;
                                n_pending = ST_NO_DATA;
                            end else if (!fmt_ok) begin
                                n_phase   = PH_DONE;
                                n_pending = ST_BAD_FORMAT;
                            end else if (asm_word[31:1] == 31'd0) begin
                                n_phase   = PH_DONE;
                                n_pending = ST_OK;
                            end else begin
                                n_remaining = {1'b0, asm_word[31:1]};
                                n_phase     = PH_SAMPLES;
                                n_pos       = 4'd0;
                            end
                        end else if (asm_word == 32'd0) begin
                            n_phase = PH_CHUNK;
                            n_pos   = 4'd0;
                        end else begin
                            n_remaining = asm_word;
                            n_phase     = PH_SKIP;
                        end
                    end
                end
                PH_FMT: begin
                    n_shift = asm_word;
                    n_pos   = r_pos + 4'd1;
                    case (r_pos)
                        4'd1:    n_format   = asm_word[31:16];
                        4'd3:    n_channels = asm_word[31:16];
                        4'd7:    n_rate     = asm_word;
                        4'd15:   n_bits     = asm_word[31:16];
                        default: ;
                    endcase
                    if (r_pos == 4'd15) begin
                        if (r_remaining > FMT_BODY_BYTES) begin
                            n_remaining = r_remaining - FMT_BODY_BYTES;
                            n_phase     = PH_SKIP;
                        end else begin
                            n_phase = PH_CHUNK;
                            n_pos   = 4'd0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_HEADER;
            r_pos       <= 4'd0;
            r_shift     <= 32'd0;
            r_tag       <= 32'd0;
            r_remaining <= 32'd0;
            r_format    <= 16'd0;
            r_channels  <= 16'd0;
            r_rate      <= 32'd0;
            r_bits      <= 16'd0;
            r_low       <= 8'd0;
            r_pending   <= ST_OK;
        end else if (i_step) begin
            r_phase     <= n_phase;
            r_pos       <= n_pos;
            r_shift     <= n_shift;
            r_tag       <= n_tag;
            r_remaining <= n_remaining;
            r_format    <= n_format;
            r_channels  <= n_channels;
            r_rate      <= n_rate;
            r_bits      <= n_bits;
            r_low       <= n_low;
            r_pending   <= n_pending;
        end
    end

    `ASSERT_IMP(a_samples_left, i_clk, i_rst_n, r_phase == PH_SAMPLES, r_remaining != 32'd0)
    `ASSERT_IMP(a_sample_pos, i_clk, i_rst_n, r_phase == PH_SAMPLES, r_pos[3:1] == 3'd0)
    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, i_step && i_item.end_marker, r_phase == PH_HEADER && r_pos == 4'd0)

endmodule

FILE: hdl/wavps_out_reg.sv
// ----------------------------------------------------------------------------
// wavps_out_reg
// Result register; holds a word while the consumer stalls.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wavps_out_reg import wavps_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_vld, n_vld;
    t_result r_res;

    // slot can take a word when empty or when the held one leaves this cycle
    assign o_free = !r_vld || !i_stall;

    always_comb begin
        if (i_load) begin
            n_vld = 1'b1;
        end else if (i_stall) begin
            n_vld = r_vld;
        end else begin
            n_vld = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else begin
            r_vld <= n_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_result;
        end
    end

    assign o_valid  = r_vld;
    assign o_result = r_res;

    `ASSERT_IMP(a_status_is_last, i_clk, i_rst_n, r_vld && r_res.result_kind == RES_STATUS, r_res.last_result)
    `ASSERT_IMP(a_sample_clean, i_clk, i_rst_n, r_vld && r_res.result_kind == RES_SAMPLE, r_res.status_code == ST_OK && !r_res.last_result)

endmodule

FILE: hdl/wav_pcm16_stream_parser_core.sv
// ----------------------------------------------------------------------------
// wav_pcm16_stream_parser_core
// RIFF/WAV byte stream parser emitting mono 16-bit PCM samples (Q1.15) and
// one final status word per file.
//
//   channel  dir  handshake              payload
//   in       in   i_in_valid/o_in_stall  i_data_byte, i_end_marker
//   out      out  o_out_valid/i_out_stall o_sample_value, o_result_kind,
//                                        o_status_code, o_last_result
//   cfg      in   i_cfg_valid/o_cfg_ready i_cfg_data (required sample rate)
//
// One byte per cycle sustained unless the result register is held by
// i_out_stall; a word passes the input register, then the parse step into the
// result register. Reset is synchronous; no clearing pass.
// o_in_stall rises only when the result register is held by i_out_stall and
// the buffered byte would produce a result; bytes with no result keep moving.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module wav_pcm16_stream_parser_core import wavps_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [7:0]         i_data_byte,
    input  logic               i_end_marker,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_sample_value,
    output logic               o_result_kind,
    output logic [2:0]         o_status_code,
    output logic               o_last_result,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [31:0]        i_cfg_data
);

    logic        r_in_vld, n_in_vld;
    t_item       r_item;
    logic [31:0] r_req_rate;
    logic        in_accept;
    logic        step;
    logic        produce;
    logic        out_free;
    t_result     step_result;
    t_result     out_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_req_rate <= RATE_AT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_req_rate <= i_cfg_data;
        end
    end

    // buffered word advances unless it needs the result slot and that is held
    assign step       = r_in_vld && (out_free || !produce);
    assign o_in_stall = r_in_vld && !step;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        if (in_accept) begin
            n_in_vld = 1'b1;
        end else if (step) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= n_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_item.data_byte  <= i_data_byte;
            r_item.end_marker <= i_end_marker;
        end
    end

    wavps_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_item     (r_item),
        .i_req_rate (r_req_rate),
        .o_produce  (produce),
        .o_result   (step_result)
    );

    wavps_out_reg u_out_reg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step && produce),
        .i_result (step_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_sample_value = out_result.sample_value;
    assign o_result_kind  = out_result.result_kind;
    assign o_status_code  = out_result.status_code;
    assign o_last_result  = out_result.last_result;

    `ASSERT_IMP(a_stall_needs_full, i_clk, i_rst_n, o_in_stall, o_out_valid && i_out_stall)

endmodule
